// ----- src/difficulty_retarget_unit_macros.svh -----
// assertion macros for the difficulty retarget unit checker
`ifndef DIFFICULTY_RETARGET_UNIT_MACROS_SVH
`define DIFFICULTY_RETARGET_UNIT_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define DRU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("difficulty retarget check failed");

// next-cycle implication, sampled on aclk, off during reset
`define DRU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("difficulty retarget check failed");

`endif

// ----- src/dru_pkg.sv -----
`default_nettype none

package dru_pkg;

    localparam int TARGET_BITS_DEF    = 256;
    localparam int DIV_BITS_PER_STAGE = 4;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int DIVR_W    = 32;
    localparam int SPAN_W    = 34;
    localparam int MANT_W    = 23;
    localparam int SHIFT_W   = 11;
    localparam int PROD_W    = MANT_W + SPAN_W;

    localparam logic [31:0] TIMESPAN_RST   = 32'd302400;
    localparam logic [63:0] LIMIT_TOP_RST  = 64'h0000_0FFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_LOW_RST  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NO_RETARGET = 3'd0,
        CFG_TIMESPAN    = 3'd1,
        CFG_LIMIT3      = 3'd2,
        CFG_LIMIT2      = 3'd3,
        CFG_LIMIT1      = 3'd4,
        CFG_LIMIT0      = 3'd5
    } cfg_idx_t;

    // sideband that travels with each request
    typedef struct packed {
        logic        halve;
        logic [31:0] last_bits;
    } side_t;

endpackage

`default_nettype wire

// ----- src/difficulty_retarget_unit.sv -----
`default_nettype none

// difficulty retarget over compact targets: each request carries the last compact
// target, the last block time and the window's first block time, and yields one
// compact next target. the span is clamped to a quarter and four times the target
// timespan, the decoded target is scaled by span / timespan (halved first and doubled
// after when it comes close to the limit), capped at the limit and re-encoded, or
// passed through unchanged when no_retarget is set. a new request is taken every
// cycle while no result waits on m_ready; the pipelined divider produces DIV_BPS
// quotient bits per stage. the whole pipeline moves on together and holds while a result
// waits on m_ready. configuration is written with cfg_valid / cfg_ready, always ready.
module difficulty_retarget_unit #(
    parameter int TARGET_BITS = dru_pkg::TARGET_BITS_DEF,
    parameter int DIV_BPS     = dru_pkg::DIV_BITS_PER_STAGE
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [31:0]                   s_last_bits,
    input  wire logic [31:0]                   s_last_time,
    input  wire logic [31:0]                   s_first_time,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [31:0]                        m_next_bits,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dru_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dru_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam int TB          = TARGET_BITS;
    localparam int DIV_STAGES  = (TB + DIV_BPS - 1) / DIV_BPS;
    localparam int PW          = DIV_STAGES * DIV_BPS;
    localparam int NBYTES      = (TB + 7) / 8;
    localparam int VW          = NBYTES * 8;
    localparam int VIDX_W      = $clog2(VW);
    localparam int SIZE_W      = $clog2(NBYTES + 1);
    localparam int SMEAR_STEPS = $clog2(TB);
    localparam int MW          = dru_pkg::MANT_W;
    localparam int SW          = dru_pkg::SHIFT_W;
    localparam int DW          = dru_pkg::DIVR_W;

    // whole pipeline steps together unless a result is held
    logic advance;
    assign advance   = !m_valid || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    // ---------------- configuration registers ----------------
    logic        no_retarget_reg;
    logic [31:0] timespan_reg;
    logic [63:0] limit3_reg, limit2_reg, limit1_reg, limit0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            no_retarget_reg <= 1'b0;
            timespan_reg    <= dru_pkg::TIMESPAN_RST;
            limit3_reg      <= dru_pkg::LIMIT_TOP_RST;
            limit2_reg      <= dru_pkg::LIMIT_LOW_RST;
            limit1_reg      <= dru_pkg::LIMIT_LOW_RST;
            limit0_reg      <= dru_pkg::LIMIT_LOW_RST;
        end else if (cfg_valid) begin
            unique case (dru_pkg::cfg_idx_t'(cfg_index))
                dru_pkg::CFG_NO_RETARGET: no_retarget_reg <= cfg_data[0];
                dru_pkg::CFG_TIMESPAN:    timespan_reg    <= cfg_data[31:0];
                dru_pkg::CFG_LIMIT3:      limit3_reg      <= cfg_data;
                dru_pkg::CFG_LIMIT2:      limit2_reg      <= cfg_data;
                dru_pkg::CFG_LIMIT1:      limit1_reg      <= cfg_data;
                dru_pkg::CFG_LIMIT0:      limit0_reg      <= cfg_data;
                default: ; // unknown index, dropped
            endcase
        end
    end

    logic [255:0]  limit_full;
    logic [TB-1:0] limit;
    assign limit_full = {limit3_reg, limit2_reg, limit1_reg, limit0_reg};
    assign limit      = limit_full[TB-1:0];

    // mask of every bit below the limit's top bit, refreshed each cycle
    logic [TB-1:0] lmask_reg, lmask_next;
    logic          lnz_reg;

    always_comb begin
        logic [TB-1:0] sm;
        sm = limit;
        for (int k = 0; k < SMEAR_STEPS; k++) begin
            sm = sm | (sm >> (1 << k));
        end
        lmask_next = sm >> 1;
    end

    always_ff @(posedge aclk) begin
        lmask_reg <= lmask_next;
        lnz_reg   <= |limit;
    end

    // ---------------- stage a: span clamp and compact decode ----------------
    logic signed [34:0] span_raw, span_lo, span_hi, span_cl;
    logic [7:0]         dec_exp;
    logic [MW-1:0]      dec_m, dec_m3;
    logic [SW-1:0]      dec_s, dec_left;

    assign span_raw = $signed({3'b000, s_last_time}) - $signed({3'b000, s_first_time});
    assign span_lo  = $signed({5'b00000, timespan_reg[31:2]});
    assign span_hi  = $signed({1'b0, timespan_reg, 2'b00});

    always_comb begin
        if (span_raw < span_lo) begin
            span_cl = span_lo;
        end else if (span_raw > span_hi) begin
            span_cl = span_hi;
        end else begin
            span_cl = span_raw;
        end
    end

    assign dec_exp = s_last_bits[31:24];

    always_comb begin
        if (dec_exp <= 8'd3) begin
            // small exponent: low mantissa bytes fall off
            dec_m = s_last_bits[MW-1:0] >> {2'(2'd3 - dec_exp[1:0]), 3'b000};
            dec_s = '0;
        end else begin
            dec_m = s_last_bits[MW-1:0];
            dec_s = {8'(dec_exp - 8'd3), 3'b000};
        end
        dec_left = SW'(TB) - dec_s;
        // mantissa bits shifted past the top are dropped
        if (dec_s >= SW'(TB)) begin
            dec_m3 = '0;
        end else if (dec_left < SW'(MW)) begin
            dec_m3 = dec_m & ~({MW{1'b1}} << dec_left[4:0]);
        end else begin
            dec_m3 = dec_m;
        end
    end

    logic                         a_valid_reg;
    dru_pkg::side_t               a_side_reg;
    logic [dru_pkg::SPAN_W-1:0]   a_span_reg;
    logic [MW-1:0]                a_m_reg;
    logic [SW-1:0]                a_s_reg;
    logic [TB-1:0]                a_d_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_side_reg.halve     <= 1'b0;
            a_side_reg.last_bits <= s_last_bits;
            a_span_reg           <= span_cl[dru_pkg::SPAN_W-1:0];
            a_m_reg              <= dec_m3;
            a_s_reg              <= dec_s;
            a_d_reg              <= TB'(dec_m) << dec_s;
        end
    end

    // ---------------- stage b: halving decision ----------------
    logic          b_halve;
    logic [MW-1:0] b_m_next;
    logic [SW-1:0] b_s_next;

    assign b_halve = lnz_reg && (|(a_d_reg & ~lmask_reg));

    always_comb begin
        b_m_next = a_m_reg;
        b_s_next = a_s_reg;
        if (b_halve) begin
            if (a_s_reg == '0) begin
                b_m_next = a_m_reg >> 1;
            end else begin
                b_s_next = a_s_reg - SW'(1);
            end
        end
    end

    logic                       b_valid_reg;
    dru_pkg::side_t             b_side_reg;
    logic [dru_pkg::SPAN_W-1:0] b_span_reg;
    logic [MW-1:0]              b_m_reg;
    logic [SW-1:0]              b_s_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_side_reg.halve     <= b_halve;
            b_side_reg.last_bits <= a_side_reg.last_bits;
            b_span_reg           <= a_span_reg;
            b_m_reg              <= b_m_next;
            b_s_reg              <= b_s_next;
        end
    end

    // ---------------- stage c: mantissa times span ----------------
    logic                       c_valid_reg;
    dru_pkg::side_t             c_side_reg;
    logic [dru_pkg::PROD_W-1:0] c_q_reg;
    logic [SW-1:0]              c_s_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            c_side_reg <= b_side_reg;
            c_q_reg    <= dru_pkg::PROD_W'(b_m_reg) * dru_pkg::PROD_W'(b_span_reg);
            c_s_reg    <= b_s_reg;
        end
    end

    // ---------------- stage d: place product, wrap at target width ----------------
    logic           d_valid_reg;
    dru_pkg::side_t d_side_reg;
    logic [TB-1:0]  d_p_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            d_side_reg <= c_side_reg;
            d_p_reg    <= TB'(c_q_reg) << c_s_reg;
        end
    end

    // valid bits of the front stages, cleared on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // ---------------- divider chain ----------------
    logic           div_valid [DIV_STAGES+1];
    dru_pkg::side_t div_side  [DIV_STAGES+1];
    logic [DW-1:0]  div_rem   [DIV_STAGES+1];
    logic [PW-1:0]  div_work  [DIV_STAGES+1];

    assign div_valid[0] = d_valid_reg;
    assign div_side[0]  = d_side_reg;
    assign div_rem[0]   = '0;
    assign div_work[0]  = PW'(d_p_reg);

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        dru_div_stage #(
            .PW  (PW),
            .BPS (DIV_BPS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .divisor   (timespan_reg),
            .in_valid  (div_valid[g]),
            .in_side   (div_side[g]),
            .in_rem    (div_rem[g]),
            .in_work   (div_work[g]),
            .out_valid (div_valid[g+1]),
            .out_side  (div_side[g+1]),
            .out_rem   (div_rem[g+1]),
            .out_work  (div_work[g+1])
        );
    end

    // ---------------- stage f: undo halving, cap at limit ----------------
    logic [TB-1:0] f_q, f_q2;

    assign f_q  = div_work[DIV_STAGES][TB-1:0];
    assign f_q2 = div_side[DIV_STAGES].halve ? (f_q << 1) : f_q;

    logic           f_valid_reg;
    dru_pkg::side_t f_side_reg;
    logic [TB-1:0]  f_v_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            f_side_reg <= div_side[DIV_STAGES];
            f_v_reg    <= (f_q2 > limit) ? limit : f_q2;
        end
    end

    // ---------------- stage e1: byte length ----------------
    logic [VW-1:0]     e1_vp;
    logic [SIZE_W-1:0] e1_size_next;

    assign e1_vp = VW'(f_v_reg);

    always_comb begin
        e1_size_next = '0;
        for (int b = 0; b < NBYTES; b++) begin
            if (|e1_vp[8*b +: 8]) begin
                e1_size_next = SIZE_W'(b + 1);
            end
        end
    end

    logic              e1_valid_reg;
    dru_pkg::side_t    e1_side_reg;
    logic [VW-1:0]     e1_v_reg;
    logic [SIZE_W-1:0] e1_size_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            e1_side_reg <= f_side_reg;
            e1_v_reg    <= e1_vp;
            e1_size_reg <= e1_size_next;
        end
    end

    // ---------------- stage e2: mantissa and exponent ----------------
    logic [23:0]       e2_mant;
    logic [7:0]        e2_exp;
    logic [SIZE_W-1:0] e2_k;
    logic [31:0]       e2_bits;

    assign e2_k = e1_size_reg - SIZE_W'(3);

    always_comb begin
        if (e1_size_reg <= SIZE_W'(3)) begin
            e2_mant = e1_v_reg[23:0] << {2'(2'd3 - e1_size_reg[1:0]), 3'b000};
        end else begin
            e2_mant = e1_v_reg[VIDX_W'({e2_k, 3'b000}) +: 24];
        end
        e2_exp = 8'(e1_size_reg);
        // keep the sign bit clear: move one byte down and bump the exponent
        if (e2_mant[23]) begin
            e2_mant = e2_mant >> 8;
            e2_exp  = e2_exp + 8'd1;
        end
        if (no_retarget_reg) begin
            e2_bits = e1_side_reg.last_bits;
        end else begin
            e2_bits = {e2_exp, 1'b0, e2_mant[22:0]};
        end
    end

    logic        e2_valid_reg;
    logic [31:0] e2_bits_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            e2_bits_reg <= e2_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg  <= 1'b0;
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
        end else if (advance) begin
            f_valid_reg  <= div_valid[DIV_STAGES];
            e1_valid_reg <= f_valid_reg;
            e2_valid_reg <= e1_valid_reg;
        end
    end

    assign m_valid     = e2_valid_reg;
    assign m_next_bits = e2_bits_reg;

endmodule

`default_nettype wire

// ----- src/dru_div_stage.sv -----
`default_nettype none

module dru_div_stage #(
    parameter int PW  = 256,
    parameter int BPS = dru_pkg::DIV_BITS_PER_STAGE
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire logic [dru_pkg::DIVR_W-1:0] divisor,
    input  wire logic                       in_valid,
    input  wire dru_pkg::side_t             in_side,
    input  wire logic [dru_pkg::DIVR_W-1:0] in_rem,
    input  wire logic [PW-1:0]              in_work,
    output logic                            out_valid,
    output dru_pkg::side_t                  out_side,
    output logic [dru_pkg::DIVR_W-1:0]      out_rem,
    output logic [PW-1:0]                   out_work
);

    logic                       valid_reg;
    dru_pkg::side_t             side_reg;
    logic [dru_pkg::DIVR_W-1:0] rem_reg, rem_next;
    logic [PW-1:0]              work_reg, work_next;

    // restoring division, dividend bits shift out the top, quotient bits in at the bottom
    always_comb begin
        logic [dru_pkg::DIVR_W:0] cur;
        logic                     ge;
        rem_next  = in_rem;
        work_next = in_work;
        for (int k = 0; k < BPS; k++) begin
            cur = {rem_next, work_next[PW-1]};
            ge  = (cur >= {1'b0, divisor});
            if (ge) begin
                rem_next = dru_pkg::DIVR_W'(cur - {1'b0, divisor});
            end else begin
                rem_next = cur[dru_pkg::DIVR_W-1:0];
            end
            work_next = {work_next[PW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg <= in_side;
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_work  = work_reg;

endmodule

`default_nettype wire

// ----- src/dru_checker.sv -----
`default_nettype none

`include "difficulty_retarget_unit_macros.svh"

module dru_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_next_bits
);

    // a held result stays offered
    `DRU_ASSERT_NXT(a_m_hold, m_valid && !m_ready, m_valid)
    // and keeps its value
    `DRU_ASSERT_NXT(a_m_stable, m_valid && !m_ready, $stable(m_next_bits))
    // input only stalls behind a waiting result
    `DRU_ASSERT_IMP(a_stall_cause, !s_ready, m_valid && !m_ready)
    // a draining output never blocks a new request
    `DRU_ASSERT_IMP(a_flow, m_ready, s_ready)

endmodule

bind difficulty_retarget_unit dru_checker u_dru_checker (.*);

`default_nettype wire
